FILE: design/dq_pkg.sv
// Package for the double-ended queue: request and status codes, default sizes,
// and the command struct that the top level hands to every storage cell.
// No dependencies.
package dq_pkg;

    localparam int DQ_DEPTH_DEF     = 64;
    localparam int DQ_WORD_BITS_DEF = 32;

    localparam int OP_BITS = 3;
    localparam int ST_BITS = 2;

    localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_PEEK_BACK  = 3'd4;
    localparam logic [OP_BITS-1:0] OP_PEEK_FRONT = 3'd5;

    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_OVER  = 2'd1;
    localparam logic [ST_BITS-1:0] ST_UNDER = 2'd2;

    // One-hot cell command; at most one member is set in a cycle.
    typedef struct packed {
        logic shift_right;  // push front: every word moves one cell back
        logic shift_left;   // pop front: every word moves one cell forward
        logic load_back;    // push back: first empty cell takes the new word
        logic clear_back;   // pop back: last occupied cell empties
    } t_cell_cmd;

endpackage

FILE: design/dq_if.sv
// Valid/ready channel interfaces for the double-ended queue.
// Depends on dq_pkg for the code widths.
interface dq_req_if
    import dq_pkg::*;
#(
    parameter int WORD_BITS = DQ_WORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic        [OP_BITS-1:0]   op;
    logic signed [WORD_BITS-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface dq_rsp_if
    import dq_pkg::*;
#(
    parameter int WORD_BITS = DQ_WORD_BITS_DEF,
    parameter int FILL_BITS = $clog2(DQ_DEPTH_DEF + 1)
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] data;
    logic        [ST_BITS-1:0]   status;
    logic        [FILL_BITS-1:0] fill;

    modport source (output valid, output data, output status, output fill, input ready);
    modport sink   (input valid, input data, input status, input fill, output ready);
endinterface

FILE: design/double_ended_queue.sv
// Top level of the double-ended queue: request decode, the row of storage
// cells and the response register. Depends on dq_pkg, dq_if and dq_cell.
//
//  channel  | dir | payload                    | handshake
//  ---------+-----+----------------------------+----------------------
//  i_req    | in  | op, value                  | valid/ready, word taken
//  o_rsp    | out | data, status, fill         | valid/ready, word taken
//
// Each request word is decoded against the count register,
// one command goes to every cell, and the response word is registered.
// A new request word is taken every cycle while the response register is empty
// or being drained; a stalled o_rsp holds i_req.ready low until it drains.
// Reset empties all cells and clears the count; stored words are not cleared.
// The front word sits in cell 0; the back word is the last occupied cell.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH     = DQ_DEPTH_DEF,
    parameter int WORD_BITS = DQ_WORD_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);

    localparam int FILL_BITS = $clog2(DEPTH + 1);
    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(DEPTH);

    // Count and response register.
    logic [FILL_BITS-1:0] r_count;
    logic [FILL_BITS-1:0] n_count;
    logic                 r_rsp_valid;
    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic [ST_BITS-1:0]   r_status;
    logic [ST_BITS-1:0]   n_status;

    logic      accept;
    logic      empty;
    logic      full;
    t_cell_cmd cmd;

    // Cell row taps.
    logic [WORD_BITS-1:0] w_word [DEPTH];
    logic                 w_occ  [DEPTH];
    logic [WORD_BITS-1:0] w_back [DEPTH];
    logic [WORD_BITS-1:0] back_word;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign empty       = (r_count == '0);
    assign full        = (r_count == FILL_FULL);

    // Only the last occupied cell drives a nonzero back tap; OR them together.
    always_comb begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_word = back_word | w_back[i];
        end
    end

    // Decode the request word into a cell command and the response fields.
    always_comb begin
        cmd      = '0;
        n_count  = r_count;
        n_data   = '0;
        n_status = ST_OK;
        case (i_req.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_OVER;
                end else begin
                    cmd.load_back   = accept && (i_req.op == OP_PUSH_BACK);
                    cmd.shift_right = accept && (i_req.op == OP_PUSH_FRONT);
                    n_count         = r_count + 1'b1;
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (empty) begin
                    n_status = ST_UNDER;
                end else begin
                    n_data = back_word;
                    if (i_req.op == OP_POP_BACK) begin
                        cmd.clear_back = accept;
                        n_count        = r_count - 1'b1;
                    end
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status = ST_UNDER;
                end else begin
                    n_data = w_word[0];
                    if (i_req.op == OP_POP_FRONT) begin
                        cmd.shift_left = accept;
                        n_count        = r_count - 1'b1;
                    end
                end
            end
            default: begin
                // Unused codes: leave the state alone and answer ok.
            end
        endcase
    end

    // Row of cells; cell 0 sees the incoming word as its left neighbor,
    // and the last cell sees an always-empty right neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic                 left_occ;
        logic [WORD_BITS-1:0] right_word;
        logic                 right_occ;

        if (g == 0) begin : g_first
            assign left_word = i_req.value;
            assign left_occ  = 1'b1;
        end else begin : g_mid_l
            assign left_word = w_word[g-1];
            assign left_occ  = w_occ[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_word = '0;
            assign right_occ  = 1'b0;
        end else begin : g_mid_r
            assign right_word = w_word[g+1];
            assign right_occ  = w_occ[g+1];
        end

        dq_cell #(
            .WORD_BITS(WORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_value     (i_req.value),
            .i_left_word (left_word),
            .i_left_occ  (left_occ),
            .i_right_word(right_word),
            .i_right_occ (right_occ),
            .o_word      (w_word[g]),
            .o_occ       (w_occ[g]),
            .o_back_word (w_back[g])
        );
    end

    // Advance the count and load the response register on an accepted word;
    // drop the response once the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid  = r_rsp_valid;
    assign o_rsp.data   = r_data;
    assign o_rsp.status = r_status;
    assign o_rsp.fill   = r_count;

endmodule

FILE: design/dq_cell.sv
// One storage cell of the deque chain: a word and an occupied flag.
// Depends on dq_pkg for the cell command struct.
module dq_cell
    import dq_pkg::*;
#(
    parameter int WORD_BITS = DQ_WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_cmd            i_cmd,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [WORD_BITS-1:0] i_left_word,
    input  logic                 i_left_occ,
    input  logic [WORD_BITS-1:0] i_right_word,
    input  logic                 i_right_occ,
    output logic [WORD_BITS-1:0] o_word,
    output logic                 o_occ,
    output logic [WORD_BITS-1:0] o_back_word
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 r_occ;
    logic                 n_occ;
    logic                 is_last;

    assign is_last = r_occ && !i_right_occ;

    always_comb begin
        n_word = r_word;
        n_occ  = r_occ;
        if (i_cmd.shift_right) begin
            n_word = i_left_word;
            n_occ  = i_left_occ;
        end else if (i_cmd.shift_left) begin
            n_word = i_right_word;
            n_occ  = i_right_occ;
        end else if (i_cmd.load_back && !r_occ && i_left_occ) begin
            n_word = i_value;
            n_occ  = 1'b1;
        end else if (i_cmd.clear_back && is_last) begin
            n_occ  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_word      = r_word;
    assign o_occ       = r_occ;
    assign o_back_word = is_last ? r_word : '0;

endmodule

FILE: design/dq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on dq_pkg for the status codes.
module dq_checker
    import dq_pkg::*;
#(
    parameter int DEPTH     = DQ_DEPTH_DEF,
    parameter int WORD_BITS = DQ_WORD_BITS_DEF,
    parameter int FILL_BITS = $clog2(DEPTH + 1)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic [WORD_BITS-1:0] i_rsp_data,
    input logic [ST_BITS-1:0]   i_rsp_status,
    input logic [FILL_BITS-1:0] i_rsp_fill
);

    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(DEPTH);

    // Every accepted request word yields a response word in the next cycle.
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> i_rsp_valid)
        else $error("no response after accepted request");

    // Overflow is only reported with the deque full.
    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == ST_OVER) |-> (i_rsp_fill == FILL_FULL))
        else $error("overflow reported while not full");

    // Underflow is only reported with the deque empty and no data.
    a_under_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == ST_UNDER) |-> (i_rsp_fill == '0 && i_rsp_data == '0))
        else $error("underflow reported with data or nonzero fill");

    // Fill between responses moves by at most one word.
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && $past(i_rsp_valid) && $past(i_rst_n)) |->
        (i_rsp_fill == $past(i_rsp_fill) || i_rsp_fill == $past(i_rsp_fill) + 1'b1
         || i_rsp_fill == $past(i_rsp_fill) - 1'b1))
        else $error("fill jumped by more than one");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_data) && $stable(i_rsp_status) && $stable(i_rsp_fill)))
        else $error("stalled response changed");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS),
    .FILL_BITS(FILL_BITS)
) u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data),
    .i_rsp_status(o_rsp.status),
    .i_rsp_fill  (o_rsp.fill)
);

FILE: tb/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue: directed and random requests with a mirror model.
// Depends on dq_pkg, dq_if and the double_ended_queue RTL.
module double_ended_queue_tb;
    import dq_pkg::*;

    localparam int DEPTH           = DQ_DEPTH_DEF;
    localparam int WORD_BITS       = DQ_WORD_BITS_DEF;
    localparam int FILL_BITS       = $clog2(DEPTH + 1);
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int TAIL_CYCLES     = 16;
    localparam int LIMIT_NS        = 4_000_000;

    // Op codes the block treats as no-ops; the package leaves them unnamed.
    localparam logic [OP_BITS-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_RSVD_7 = 3'd7;

    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    // Request mix of one random segment: mostly pushes, mostly reads, or even.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_op_mix;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] data;
        logic        [ST_BITS-1:0]   status;
        logic        [FILL_BITS-1:0] fill;
    } t_deque_result;

    // Mirror of the deque contents. Every accepted request word is applied here
    // and its response is queued; every response word from the block is checked
    // against the oldest queued one.
    class deque_mirror;
        logic signed [WORD_BITS-1:0] cells [DEPTH];
        int                          front;
        int                          stored;
        t_deque_result               awaited_results [$];
        int                          errors;

        function new();
            front  = 0;
            stored = 0;
            errors = 0;
        endfunction

        function void apply_request(logic [OP_BITS-1:0] op, logic signed [WORD_BITS-1:0] value);
            t_deque_result r;
            int            idx;
            r.data   = '0;
            r.status = ST_OK;
            case (op)
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                    if (stored == DEPTH) begin
                        r.status = ST_OVER;
                    end else if (op == OP_PUSH_BACK) begin
                        cells[(front + stored) % DEPTH] = value;
                        stored++;
                    end else begin
                        front        = (front + DEPTH - 1) % DEPTH;
                        cells[front] = value;
                        stored++;
                    end
                end
                OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
                    if (stored == 0) begin
                        r.status = ST_UNDER;
                    end else begin
                        idx = (op == OP_POP_BACK || op == OP_PEEK_BACK) ?
                              (front + stored - 1) % DEPTH : front;
                        r.data = cells[idx];
                        if (op == OP_POP_BACK) begin
                            stored--;
                        end else if (op == OP_POP_FRONT) begin
                            front = (front + 1) % DEPTH;
                            stored--;
                        end
                    end
                end
                default: ;
            endcase
            r.fill = FILL_BITS'(stored);
            awaited_results.push_back(r);
        endfunction

        function int words_outstanding();
            return awaited_results.size();
        endfunction

        // Print one line per mismatch and count every one.
        task flag_mismatch(input string msg);
            errors++;
            $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        task check_response(input logic signed [WORD_BITS-1:0] data,
                            input logic [ST_BITS-1:0] status,
                            input logic [FILL_BITS-1:0] fill);
            t_deque_result want;
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected response data %0d status %0d fill %0d",
                                        data, status, fill));
                return;
            end
            want = awaited_results.pop_front();
            if (data !== want.data) begin
                flag_mismatch($sformatf("data %0d, want %0d", data, want.data));
            end
            if (status !== want.status) begin
                flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
            end
            if (fill !== want.fill) begin
                flag_mismatch($sformatf("fill %0d, want %0d", fill, want.fill));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Stall controls, changed per phase; the sender and the receiver each sample their own.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Flip to ask the receiver for one long hold-off.
    bit hold_toggle    = 1'b0;

    deque_mirror mirror = new();

    dq_req_if #(.WORD_BITS(WORD_BITS)) req_ch ();
    dq_rsp_if #(.WORD_BITS(WORD_BITS), .FILL_BITS(FILL_BITS)) rsp_ch ();

    double_ended_queue #(
        .DEPTH    (DEPTH),
        .WORD_BITS(WORD_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Offer one request word, with random idle cycles ahead of it, and hold it
    // until the block takes it. Leave valid high on return so that back-to-back
    // words flow without a bubble; the next call or a drain lowers it.
    task automatic send_word(input logic [OP_BITS-1:0] op,
                             input logic signed [WORD_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        mirror.apply_request(op, value);
    endtask

    // Drop valid and hold off until every response word has come back, then
    // realign to a rising edge for the next drive.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (mirror.words_outstanding() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [OP_BITS-1:0] any_push();
        return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    endfunction

    function automatic logic [OP_BITS-1:0] any_read();
        case ($urandom_range(3))
            0:       return OP_POP_BACK;
            1:       return OP_POP_FRONT;
            2:       return OP_PEEK_BACK;
            default: return OP_PEEK_FRONT;
        endcase
    endfunction

    // Random segments alternate between filling, draining and an even mix, so
    // the deque keeps swinging between full and empty and both ends wrap.
    // Early in the phase ask the receiver for a long hold-off while words keep
    // coming, then pause the sender at the end until everything has drained.
    task automatic run_random_phase(input int n_items, input int send_pct, input int recv_pct);
        int                          done_items;
        int                          seg_left;
        int                          roll;
        bit                          held;
        t_op_mix                     mix;
        logic [OP_BITS-1:0]          op;
        logic signed [WORD_BITS-1:0] value;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        done_items     = 0;
        seg_left       = 0;
        held           = 1'b0;
        mix            = MIX_FILL;
        while (done_items < n_items) begin
            if (done_items == 40 && !held) begin
                hold_toggle <= ~hold_toggle;
                held = 1'b1;
            end
            if (seg_left == 0) begin
                mix      = t_op_mix'($urandom_range(2));
                seg_left = $urandom_range(60, 200);
            end
            seg_left--;
            roll = $urandom_range(99);
            if (roll < 4) begin
                op = $urandom_range(1) ? OP_RSVD_6 : OP_RSVD_7;
            end else begin
                case (mix)
                    MIX_FILL:  op = (roll < 85) ? any_push() : any_read();
                    MIX_DRAIN: op = (roll < 15) ? any_push() : any_read();
                    default:   op = (roll < 50) ? any_push() : any_read();
                endcase
            end
            case ($urandom_range(15))
                0:       value = WORD_MIN;
                1:       value = WORD_MAX;
                2:       value = '0;
                3:       value = '1;
                default: value = $urandom;
            endcase
            send_word(op, value);
            // Ignored op codes do not count toward the phase length.
            if (op != OP_RSVD_6 && op != OP_RSVD_7) begin
                done_items++;
            end
        end
        wait_drained();
    endtask

    // Receiver: take response words with random back-pressure. On a hold-off
    // request, drop ready for a long fixed stretch so the response register
    // stays full and the block stalls its request side.
    initial begin
        bit seen_toggle;
        seen_toggle  = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Check every response word taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            mirror.check_response(rsp_ch.data, rsp_ch.status, rsp_ch.fill);
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.op    = OP_PUSH_BACK;
        req_ch.value = '0;
        i_rst_n      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reads on an empty deque must underflow; spare op codes are no-ops.
        send_word(OP_POP_BACK, WORD_MAX);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_PEEK_BACK, '1);
        send_word(OP_PEEK_FRONT, WORD_MIN);
        send_word(OP_RSVD_6, WORD_MAX);
        send_word(OP_RSVD_7, '1);

        // Push the extreme words at both ends, then peek both ends.
        send_word(OP_PUSH_BACK, WORD_MAX);
        send_word(OP_PUSH_FRONT, WORD_MIN);
        send_word(OP_PUSH_BACK, '0);
        send_word(OP_PUSH_FRONT, '1);
        send_word(OP_PEEK_BACK, '0);
        send_word(OP_PEEK_FRONT, '0);
        send_word(OP_RSVD_6, $urandom);
        send_word(OP_RSVD_7, $urandom);

        // Drain from alternating ends; the mirror's front pointer wraps back to zero
        // when the deque goes empty, then check empty again and refill.
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_BACK, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_BACK, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_PEEK_BACK, '0);
        send_word(OP_PUSH_FRONT, 32'sh5555_5555);
        send_word(OP_PUSH_BACK, 32'shAAAA_AAAA);
        send_word(OP_POP_BACK, '0);
        send_word(OP_POP_FRONT, '0);
        wait_drained();

        // Sender idles a quarter of the time and the receiver most of it, then
        // the reverse, then full rate on both sides.
        run_random_phase(420, 25, 59);
        run_random_phase(420, 59, 25);
        run_random_phase(410, 0, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("double_ended_queue_tb: done, clean");
        end else begin
            $display("double_ended_queue_tb: done, errors");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(LIMIT_NS);
        $display("double_ended_queue_tb: done, errors");
        $finish;
    end

endmodule
